### hw/rtl/table_linear_interpolator_assert.svh
// Assertion macros used by the port-level checker.
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TLI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("table interpolator check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define TLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("table interpolator check failed");

`endif

### hw/rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Types and constants of the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 11;
  localparam int INDEX_W     = 10;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CNT_W-1:0] RESET_ENTRIES = CNT_W'(920);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [PADDR_W-3:0] REG_ENTRIES = '0;

  typedef struct packed {
    logic                  cmd;
    logic [INDEX_W-1:0]    entry_index;
    logic [DATA_WIDTH-1:0] breakpoint_x;
    logic [DATA_WIDTH-1:0] breakpoint_y;
    logic [DATA_WIDTH-1:0] query_x;
  } tli_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] interp_value;
    logic                  status;
  } tli_out_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] x;
    logic [DATA_WIDTH-1:0] y;
  } tli_entry_t;

  typedef struct packed {
    logic                  go;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] d;
  } tli_md_req_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] quot;
    logic                  inexact;
  } tli_md_rsp_t;

endpackage

### hw/rtl/tli_table.sv
// ----------------------------------------------------------------------------
// tli_table
// Breakpoint memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tli_table
  import tli_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  tli_entry_t        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output tli_entry_t        rd_data
);

  tli_entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/tli_muldiv.sv
// ----------------------------------------------------------------------------
// tli_muldiv
// Iterative a*b/d: a multiply step, then restoring division at two
// quotient bits per cycle. Requires a*b/d below 2^DATA_WIDTH.
// ----------------------------------------------------------------------------
module tli_muldiv
  import tli_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tli_md_req_t req,
  output tli_md_rsp_t rsp
);

  localparam int STEPS = DATA_WIDTH / 2;
  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

  mstate_t                 state;
  logic [DATA_WIDTH-1:0]   a_r;
  logic [DATA_WIDTH-1:0]   b_r;
  logic [DATA_WIDTH-1:0]   d_r;
  logic [DATA_WIDTH-1:0]   rem;
  logic [DATA_WIDTH-1:0]   low;
  logic [STEP_W-1:0]       count;
  logic                    done;
  logic [2*DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH:0]     r1;
  logic [DATA_WIDTH:0]     r2;
  logic [DATA_WIDTH-1:0]   rem1;
  logic [DATA_WIDTH-1:0]   rem_next;
  logic                    q1;
  logic                    q2;

  assign prod = {{DATA_WIDTH{1'b0}}, a_r} * {{DATA_WIDTH{1'b0}}, b_r};

  // Two chained compare-subtract steps; remainder stays below d.
  always_comb begin
    r1   = {rem, low[DATA_WIDTH-1]};
    q1   = (r1 >= {1'b0, d_r});
    rem1 = q1 ? DATA_WIDTH'(r1 - {1'b0, d_r}) : r1[DATA_WIDTH-1:0];
    r2   = {rem1, low[DATA_WIDTH-2]};
    q2   = (r2 >= {1'b0, d_r});
    rem_next = q2 ? DATA_WIDTH'(r2 - {1'b0, d_r}) : r2[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.go) begin
            a_r   <= req.a;
            b_r   <= req.b;
            d_r   <= req.d;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          // Upper half is already below d since the quotient fits.
          rem   <= prod[2*DATA_WIDTH-1:DATA_WIDTH];
          low   <= prod[DATA_WIDTH-1:0];
          count <= STEP_W'(STEPS - 1);
          state <= M_DIV;
        end
        M_DIV: begin
          rem   <= rem_next;
          low   <= {low[DATA_WIDTH-3:0], q1, q2};
          count <= count - 1'b1;
          if (count == '0) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.quot    = low;
  assign rsp.inexact = (rem != '0);

endmodule

### hw/rtl/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a loaded breakpoint table.
// ----------------------------------------------------------------------------
// Command channel: an item is taken when start is high and busy is low.
// A load item (cmd = load) writes one breakpoint and its value in that cycle
// and gives no result; busy stays low, so loads can follow back to back.
// A query item gives one result on the result port, marked by result_valid
// for exactly one cycle. With fewer than two entries in use the result comes
// in the next cycle and busy stays low; otherwise busy rises and drops in the
// result cycle. A query runs the range check against the first and last entry,
// the bisection steps (about log2(n) for n entries in use), the fetch of both
// segment ends, then the multiply-divide unit: a hand-off, a multiply, the
// divide steps and a completion step. An out-of-range query answers without
// a search. The divider and the single table read port set the query time.
// The user must write entries_in_use over the APB port only while no query
// is in flight; the block itself does not enforce it.
// Reset clears the sequencer and sets entries_in_use to 920; table contents
// are undefined until loaded. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module table_linear_interpolator
  import tli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tli_in_t            item,
  output logic               result_valid,
  output tli_out_t           result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SUM_W = ADDR_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK_LO, S_CHK_HI, S_SEARCH, S_FETCH0, S_FETCH1, S_MULDIV
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      entries_in_use;
  logic [DATA_WIDTH-1:0] qx;
  logic [ADDR_W-1:0]     lo;
  logic [ADDR_W-1:0]     hi;
  logic [DATA_WIDTH-1:0] x0;
  logic [DATA_WIDTH-1:0] y0;
  logic [DATA_WIDTH-1:0] span;
  logic [DATA_WIDTH-1:0] dx;
  logic [DATA_WIDTH-1:0] diff;
  logic                  neg;
  logic                  md_go;

  logic                  accept;
  logic                  cfg_wr;
  logic [CNT_W-1:0]      n_sat;
  logic                  few;
  logic [ADDR_W-1:0]     last;
  logic [ADDR_W-1:0]     lo_next;
  logic [ADDR_W-1:0]     hi_next;
  logic [ADDR_W-1:0]     mid;
  logic [ADDR_W-1:0]     mid_next;
  logic                  more;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  tli_entry_t            wr_data;
  tli_entry_t            rd_data;
  tli_md_req_t           md_req;
  tli_md_rsp_t           md_rsp;
  logic [DATA_WIDTH:0]   up_sum;
  logic [DATA_WIDTH-1:0] up_val;
  logic [DATA_WIDTH-1:0] down_q;
  logic [DATA_WIDTH-1:0] down_val;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= RESET_ENTRIES;
    end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_ENTRIES) begin
      entries_in_use <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_ENTRIES) begin
      prdata = PDATA_W'(entries_in_use);
    end
  end

  // ---------------------------------------------------------------- table
  assign accept  = start && !busy;
  assign wr_en   = accept && item.cmd == CMD_LOAD
                   && 32'(item.entry_index) < MAX_ENTRIES;
  assign wr_data = '{x: item.breakpoint_x, y: item.breakpoint_y};

  tli_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(item.entry_index)),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------- search
  assign n_sat = (32'(entries_in_use) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                     : entries_in_use;
  assign few   = (n_sat < CNT_W'(2));
  assign last  = ADDR_W'(n_sat - 1'b1);
  assign mid   = ADDR_W'((SUM_W'(lo) + SUM_W'(hi)) >> 1);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (state == S_CHK_HI) begin
      lo_next = '0;
      hi_next = last;
    end else if (state == S_SEARCH) begin
      if (qx >= rd_data.x) begin
        lo_next = mid;
      end else begin
        hi_next = mid;
      end
    end
    mid_next = ADDR_W'((SUM_W'(lo_next) + SUM_W'(hi_next)) >> 1);
    more     = (hi_next - lo_next) > ADDR_W'(1);
  end

  // Issue the read whose data the next state looks at.
  always_comb begin
    case (state)
      S_CHK_LO:           rd_addr = last;
      S_CHK_HI, S_SEARCH: rd_addr = more ? mid_next : lo_next;
      S_FETCH0:           rd_addr = lo + 1'b1;
      default:            rd_addr = '0;
    endcase
  end

  // ------------------------------------------------------ multiply-divide
  assign md_req = '{go: md_go, a: diff, b: dx, d: span};

  tli_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Rising segment truncates and saturates; falling segment rounds the step up.
  assign up_sum   = {1'b0, y0} + {1'b0, md_rsp.quot};
  assign up_val   = up_sum[DATA_WIDTH] ? '1 : up_sum[DATA_WIDTH-1:0];
  assign down_q   = md_rsp.quot + DATA_WIDTH'(md_rsp.inexact);
  assign down_val = y0 - down_q;

  // ------------------------------------------------------------ sequencer
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      md_go        <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      md_go        <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && item.cmd == CMD_QUERY) begin
            qx <= item.query_x;
            if (few) begin
              result       <= '{interp_value: '0, status: STATUS_RANGE};
              result_valid <= 1'b1;
            end else begin
              state <= S_CHK_LO;
            end
          end
        end
        S_CHK_LO: begin
          if (qx < rd_data.x) begin
            result       <= '{interp_value: '0, status: STATUS_RANGE};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_CHK_HI;
          end
        end
        S_CHK_HI: begin
          if (qx > rd_data.x) begin
            result       <= '{interp_value: '0, status: STATUS_RANGE};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            lo    <= lo_next;
            hi    <= hi_next;
            state <= more ? S_SEARCH : S_FETCH0;
          end
        end
        S_SEARCH: begin
          lo <= lo_next;
          hi <= hi_next;
          if (!more) begin
            state <= S_FETCH0;
          end
        end
        S_FETCH0: begin
          x0    <= rd_data.x;
          y0    <= rd_data.y;
          state <= S_FETCH1;
        end
        S_FETCH1: begin
          span <= rd_data.x - x0;
          dx   <= qx - x0;
          neg  <= (rd_data.y < y0);
          diff <= (rd_data.y < y0) ? (y0 - rd_data.y) : (rd_data.y - y0);
          if (rd_data.x == x0) begin
            // Zero-width segment: answer with the left value.
            result       <= '{interp_value: y0, status: STATUS_OK};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            md_go <= 1'b1;
            state <= S_MULDIV;
          end
        end
        S_MULDIV: begin
          if (md_rsp.done) begin
            result       <= '{interp_value: neg ? down_val : up_val,
                              status: STATUS_OK};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/tli_checker.sv
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks of the table linear interpolator, bound to the top.
// ----------------------------------------------------------------------------
`include "table_linear_interpolator_assert.svh"

module tli_assertions
  import tli_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input tli_in_t            item,
  input logic               result_valid,
  input tli_out_t           result
);

  logic query_taken;
  logic load_taken;

  assign query_taken = start && !busy && item.cmd == CMD_QUERY;
  assign load_taken  = start && !busy && item.cmd == CMD_LOAD;

  // A query either answers at once or keeps the block busy.
  `TLI_ASSERT_NEXT(a_query_busy, query_taken, busy || result_valid)
  // A load never produces a result or blocks the next item.
  `TLI_ASSERT_NEXT(a_load_quiet, load_taken, !busy && !result_valid)
  // The block only leaves busy by handing out the query's result.
  `TLI_ASSERT_NOW(a_fall_result, $fell(busy) && !$past(rst), result_valid)
  // Out-of-range answers carry a zero value.
  `TLI_ASSERT_NOW(a_range_zero, result_valid && result.status == STATUS_RANGE,
                  result.interp_value == '0)

endmodule

bind table_linear_interpolator tli_assertions u_tli_assertions (.*);

### tb/tli_checker.sv
// ----------------------------------------------------------------------------
// tli_checker
// Watches the command, result and APB channels of the table interpolator,
// keeps its own copy of the breakpoint table and the entry count, predicts
// the result of every accepted query and compares it with what comes out.
// ----------------------------------------------------------------------------
module tli_checker
  import tli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  tli_in_t            item,
  input  logic               result_valid,
  input  tli_out_t           result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  logic [DATA_WIDTH-1:0] knot_x [MAX_ENTRIES];
  logic [DATA_WIDTH-1:0] knot_y [MAX_ENTRIES];
  logic [CNT_W-1:0]      search_count;
  tli_out_t              answers_due [$];
  int                    fails;

  initial fails = 0;

  function automatic tli_out_t interpolate(input logic [DATA_WIDTH-1:0] qx);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [63:0]  x0, x1, y0, y1, span, dx, prod, quo, val;
    tli_out_t     r;
    n = (search_count > MAX_ENTRIES) ? MAX_ENTRIES : search_count;
    r.interp_value = '0;
    r.status       = STATUS_RANGE;
    if (n < 2) return r;
    if (qx < knot_x[0] || qx > knot_x[n-1]) return r;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (qx >= knot_x[mid]) lo = mid;
      else hi = mid;
    end
    x0   = {32'b0, knot_x[lo]};
    x1   = {32'b0, knot_x[lo+1]};
    y0   = {32'b0, knot_y[lo]};
    y1   = {32'b0, knot_y[lo+1]};
    span = x1 - x0;
    dx   = {32'b0, qx} - x0;
    if (span == 0) begin
      val = y0;
    end else if (y1 >= y0) begin
      prod = (y1 - y0) * dx;
      val  = y0 + prod / span;
    end else begin
      // falling segment: round the drop up so the value rounds down
      prod = (y0 - y1) * dx;
      quo  = prod / span;
      if (prod % span != 0) quo = quo + 1;
      val = y0 - quo;
    end
    if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
    r.interp_value = val[DATA_WIDTH-1:0];
    r.status       = STATUS_OK;
    return r;
  endfunction

  task automatic flag(input string what, input logic [63:0] want_v,
                      input logic [63:0] got_v);
    fails++;
    if (fails <= 10)
      $display("mismatch: %s expected %h got %h", what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    tli_out_t want;
    if (rst) begin
      search_count = RESET_ENTRIES;
      answers_due.delete();
    end else begin
      // results first: a new query may be taken at the edge that ends one
      if (result_valid) begin
        if (answers_due.size() == 0) begin
          flag("result with none due", '0, {31'b0, result});
        end else begin
          want = answers_due.pop_front();
          if (result.interp_value !== want.interp_value)
            flag("interp_value", want.interp_value, result.interp_value);
          if (result.status !== want.status)
            flag("status", want.status, result.status);
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[PADDR_W-1:2] == REG_ENTRIES) search_count = pwdata[CNT_W-1:0];
        end else if (paddr[PADDR_W-1:2] == REG_ENTRIES &&
                     prdata !== PDATA_W'(search_count)) begin
          flag("entries_in_use readback", search_count, prdata);
        end
      end
      if (start && !busy) begin
        if (item.cmd == CMD_LOAD) begin
          knot_x[item.entry_index] = item.breakpoint_x;
          knot_y[item.entry_index] = item.breakpoint_y;
        end else begin
          answers_due.push_back(interpolate(item.query_x));
        end
      end
    end
    errors  <= fails;
    pending <= answers_due.size();
  end

endmodule

### tb/table_linear_interpolator_test.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_test
// Loads the breakpoint table, runs directed queries at the table edges and
// the odd entry counts, then random phases of table rebuilds and queries
// under several entry counts, with random gaps on the command side.
// ----------------------------------------------------------------------------
module table_linear_interpolator_test;
  import tli_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PAD_W        = PDATA_W - CNT_W;
  localparam logic [PADDR_W-1:0] ENTRIES_ADDR  = {REG_ENTRIES, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = {~REG_ENTRIES, 2'b00};

  typedef enum {SPREAD, RAMP, CLUSTERED} layout_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  tli_in_t            item = '0;
  logic               result_valid;
  tli_out_t           result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  int                 cycles = 0;

  logic [DATA_WIDTH-1:0] loaded_x [MAX_ENTRIES];
  logic [DATA_WIDTH-1:0] base_x [MAX_ENTRIES];
  bit                    steady = 1'b0;

  table_linear_interpolator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tli_checker watch (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold the item until it is taken, then maybe idle for a while.
  task automatic issue(input tli_in_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (!steady && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4)) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx,
                            input logic [DATA_WIDTH-1:0] x,
                            input logic [DATA_WIDTH-1:0] y);
    tli_in_t it;
    it.cmd          = CMD_LOAD;
    it.entry_index  = idx;
    it.breakpoint_x = x;
    it.breakpoint_y = y;
    it.query_x      = $urandom;
    loaded_x[idx]   = x;
    issue(it);
  endtask

  task automatic ask(input logic [DATA_WIDTH-1:0] qx);
    tli_in_t it;
    it.cmd          = CMD_QUERY;
    it.entry_index  = INDEX_W'($urandom);
    it.breakpoint_x = $urandom;
    it.breakpoint_y = $urandom;
    it.query_x      = qx;
    issue(it);
  endtask

  // Drop start, wait for every answer, then let any load finish.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register while idle, then read the entry count back.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [CNT_W-1:0] val);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {PAD_W'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ENTRIES_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_query(input int ne);
    logic [DATA_WIDTH-1:0] lo_x;
    logic [DATA_WIDTH-1:0] hi_x;
    int                    i;
    if (ne < 2) ne = 2;
    lo_x = loaded_x[0];
    hi_x = loaded_x[ne-1];
    i    = $urandom_range(0, ne - 1);
    case ($urandom_range(0, 19))
      0, 1, 2: return loaded_x[i];
      3:       return loaded_x[i] + 1;
      4:       return loaded_x[i] - 1;
      5:       return lo_x - 1;
      6:       return hi_x + 1;
      7, 8:    return $urandom;
      default: return (lo_x <= hi_x) ? $urandom_range(hi_x, lo_x) : $urandom;
    endcase
  endfunction

  task automatic fill_table(input int count, input layout_t layout);
    logic [63:0] xv;
    logic [63:0] stride;
    int          i;
    xv     = 0;
    stride = 1;
    case (layout)
      RAMP: begin
        xv     = $urandom_range(1, 1 << 20);
        stride = ((64'hFFFF_FFFE - xv) / count) >> $urandom_range(0, 16);
        if (stride == 0) stride = 1;
      end
      CLUSTERED: begin
        xv     = $urandom_range(0, 32'hFFFF_FFFF - 4 * count);
        stride = 3;
      end
      default: ;
    endcase
    for (i = 0; i < count; i++) begin
      if (layout == SPREAD) xv = (64'hFFFF_FFFF * i) / (count - 1);
      else if (i > 0) xv = xv + $urandom_range((layout == CLUSTERED) ? 0 : 1, 32'(stride));
      load_entry(INDEX_W'(i), xv[DATA_WIDTH-1:0], pick_value());
    end
  endtask

  // Put back the ascending base table in the first ne entries where phases have overwritten it.
  task automatic restore_table(input int ne);
    int i;
    for (i = 0; i < ne; i++)
      if (loaded_x[i] != base_x[i]) load_entry(INDEX_W'(i), base_x[i], pick_value());
  endtask

  initial begin
    int              total;
    int              burst;
    int              ne;
    logic [CNT_W-1:0] raw;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fill_table(MAX_ENTRIES, RAMP);
    base_x = loaded_x;

    // directed: reset count, table edges, odd counts, flat and falling segments
    ask(base_x[0]);
    ask(base_x[919]);
    ask(base_x[0] - 1);
    ask(base_x[919] + 1);
    ask('0);
    ask('1);
    ask(base_x[460]);
    ask(base_x[300] + 1);
    ask($urandom_range(base_x[919], base_x[0]));
    write_reg(UNMAPPED_ADDR, CNT_W'($urandom));
    write_reg(ENTRIES_ADDR, CNT_W'(MAX_ENTRIES));
    ask(base_x[MAX_ENTRIES-1]);
    ask(base_x[MAX_ENTRIES-1] + 1);
    write_reg(ENTRIES_ADDR, '1);
    ask(base_x[MAX_ENTRIES-1]);
    ask(base_x[MAX_ENTRIES-2] + 3);
    write_reg(ENTRIES_ADDR, CNT_W'(0));
    ask(base_x[5]);
    write_reg(ENTRIES_ADDR, CNT_W'(1));
    ask(base_x[0]);
    write_reg(ENTRIES_ADDR, CNT_W'(2));
    load_entry(INDEX_W'(0), 32'h0000_1000, '1);
    load_entry(INDEX_W'(1), 32'h0000_1000, '0);
    ask(32'h0000_1000);
    load_entry(INDEX_W'(0), '0, '1);
    load_entry(INDEX_W'(1), '1, '0);
    ask($urandom);
    ask(32'h0000_0001);
    write_reg(ENTRIES_ADDR, CNT_W'(4));
    load_entry(INDEX_W'(2), 32'd300, 32'd7);
    load_entry(INDEX_W'(3), 32'd900, 32'd1234);
    ask(32'd400);
    ask(32'd900);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0:       raw = CNT_W'(2);
        1:       raw = CNT_W'(3);
        2, 3, 4: raw = CNT_W'($urandom_range(4, 16));
        5, 6:    raw = CNT_W'($urandom_range(17, 64));
        7:       raw = CNT_W'($urandom_range(65, 200));
        8:       raw = RESET_ENTRIES;
        9:       raw = CNT_W'(MAX_ENTRIES);
        10:      raw = CNT_W'($urandom_range(201, MAX_ENTRIES));
        default: raw = ($urandom_range(0, 1) != 0) ? CNT_W'($urandom_range(0, 1))
                                                   : CNT_W'($urandom_range(1025, 2047));
      endcase
      ne = (raw > MAX_ENTRIES) ? MAX_ENTRIES : raw;
      write_reg(ENTRIES_ADDR, raw);
      if (ne >= 2 && ne <= 200 && $urandom_range(0, 3) != 0) begin
        fill_table(ne, layout_t'($urandom_range(0, 2)));
        total += ne;
      end else if (ne > 200 && $urandom_range(0, 1) != 0) begin
        restore_table(ne);
      end
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        steady = (total >= 400 && total < 550);
        if ($urandom_range(0, 99) < 85)
          ask(pick_query(ne));
        else
          load_entry(INDEX_W'($urandom), $urandom, pick_value());
        total++;
      end
    end
    steady = 1'b0;

    settle();
    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tli_pkg.sv
hw/rtl/tli_table.sv
hw/rtl/tli_muldiv.sv
hw/rtl/table_linear_interpolator.sv
hw/rtl/tli_checker.sv
tb/tli_checker.sv
tb/table_linear_interpolator_test.sv
